>>> hw/rtl/cotq_pkg.sv
// ----------------------------------------------------------------------------
// cotq_pkg
// Shared constants and types for the conveyor object type queue.
// ----------------------------------------------------------------------------
package cotq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam int LIMIT_W = 10;
	localparam int CLASS_W = 2;
	localparam int TOTAL_W = 16;
	localparam int INDEX_W = 2;

	localparam logic [CLASS_W-1:0] CLS_EMPTY  = 2'd0;
	localparam logic [CLASS_W-1:0] CLS_LARGE  = 2'd1;
	localparam logic [CLASS_W-1:0] CLS_MEDIUM = 2'd2;
	localparam logic [CLASS_W-1:0] CLS_SMALL  = 2'd3;

	localparam logic ACT_SAMPLE  = 1'b0;
	localparam logic ACT_DEQUEUE = 1'b1;

	localparam logic [INDEX_W-1:0] REG_EMPTY_LIMIT  = 2'd0;
	localparam logic [INDEX_W-1:0] REG_SMALL_LIMIT  = 2'd1;
	localparam logic [INDEX_W-1:0] REG_MEDIUM_LIMIT = 2'd2;

	localparam logic [LIMIT_W-1:0] EMPTY_LIMIT_RST  = 10'd64;
	localparam logic [LIMIT_W-1:0] SMALL_LIMIT_RST  = 10'd128;
	localparam logic [LIMIT_W-1:0] MEDIUM_LIMIT_RST = 10'd213;

	typedef struct packed {
		logic capture;
		logic exec;
		logic load;
	} cmd_t;

endpackage

>>> hw/rtl/conveyor_object_type_queue.sv
// ----------------------------------------------------------------------------
// conveyor_object_type_queue
// Classes sensor samples, queues object types on empty-to-object edges,
// and hands back the oldest type on a dequeue request.
// ----------------------------------------------------------------------------
//  channel  handshake           payload
//  in       in_valid/in_stall   action, sample_value
//  out      out_valid/out_stall class_now, new_object, object_number,
//                               overflow_drop, dequeued_type, queue_was_empty
//  cfg      cfg_valid/cfg_ready cfg_index, cfg_data
//
//  Each item steps through capture, execute (compare, FIFO update, type store
//  read) and load result word; in_stall holds off the next item until the load.
//  The output register holds one word; a new item is taken while it waits,
//  and its load waits for out_stall to drop. No clearing pass after reset.
// ----------------------------------------------------------------------------
module conveyor_object_type_queue (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             action,
	input  logic [cotq_pkg::LIMIT_W-1:0]     sample_value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [cotq_pkg::CLASS_W-1:0]     class_now,
	output logic                             new_object,
	output logic [cotq_pkg::TOTAL_W-1:0]     object_number,
	output logic                             overflow_drop,
	output logic [cotq_pkg::CLASS_W-1:0]     dequeued_type,
	output logic                             queue_was_empty,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [cotq_pkg::INDEX_W-1:0]     cfg_index,
	input  logic [cotq_pkg::LIMIT_W-1:0]     cfg_data
);

	cotq_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;

	cotq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	cotq_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.action          (action),
		.sample_value    (sample_value),
		.cfg_valid       (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.class_now       (class_now),
		.new_object      (new_object),
		.object_number   (object_number),
		.overflow_drop   (overflow_drop),
		.dequeued_type   (dequeued_type),
		.queue_was_empty (queue_was_empty)
	);

endmodule

>>> hw/rtl/cotq_ctrl.sv
// ----------------------------------------------------------------------------
// cotq_ctrl
// Sequencer: capture, execute, load result word; tracks the output register.
// ----------------------------------------------------------------------------
module cotq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output cotq_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_LOAD = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_full_q;
	logic   out_fire;
	logic   load_ok;

	assign out_fire  = out_full_q & ~out_stall;
	assign load_ok   = (state_q == ST_LOAD) & (~out_full_q | ~out_stall);
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_full_q;

	assign cmd.capture = (state_q == ST_IDLE) & in_valid;
	assign cmd.exec    = (state_q == ST_EXEC);
	assign cmd.load    = load_ok;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (load_ok) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			out_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_ok) out_full_q <= 1'b1;
			else if (out_fire) out_full_q <= 1'b0;
		end
	end

endmodule

>>> hw/rtl/cotq_datapath.sv
// ----------------------------------------------------------------------------
// cotq_datapath
// Threshold classifier, edge detect, ring FIFO of types, counter, result word.
// ----------------------------------------------------------------------------
module cotq_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cotq_pkg::cmd_t                   cmd,
	input  logic                             action,
	input  logic [cotq_pkg::LIMIT_W-1:0]     sample_value,
	input  logic                             cfg_valid,
	input  logic [cotq_pkg::INDEX_W-1:0]     cfg_index,
	input  logic [cotq_pkg::LIMIT_W-1:0]     cfg_data,
	output logic [cotq_pkg::CLASS_W-1:0]     class_now,
	output logic                             new_object,
	output logic [cotq_pkg::TOTAL_W-1:0]     object_number,
	output logic                             overflow_drop,
	output logic [cotq_pkg::CLASS_W-1:0]     dequeued_type,
	output logic                             queue_was_empty
);

	logic [cotq_pkg::LIMIT_W-1:0] empty_limit_q;
	logic [cotq_pkg::LIMIT_W-1:0] small_limit_q;
	logic [cotq_pkg::LIMIT_W-1:0] medium_limit_q;

	logic                         action_q;
	logic [cotq_pkg::LIMIT_W-1:0] sample_q;

	logic [cotq_pkg::CLASS_W-1:0] last_class_q;
	logic [cotq_pkg::PTR_W-1:0]   head_q;
	logic [cotq_pkg::PTR_W-1:0]   tail_q;
	logic [cotq_pkg::CNT_W-1:0]   count_q;
	logic [cotq_pkg::TOTAL_W-1:0] total_q;

	logic [cotq_pkg::CLASS_W-1:0] mem_q [cotq_pkg::QUEUE_DEPTH];
	logic [cotq_pkg::CLASS_W-1:0] rd_q;

	logic [cotq_pkg::CLASS_W-1:0] res_cls_q;
	logic                         res_new_q;
	logic                         res_drop_q;
	logic                         res_empty_q;
	logic                         res_pop_q;

	logic [cotq_pkg::CLASS_W-1:0] cls;
	logic                         is_sample;
	logic                         rise;
	logic                         full;
	logic                         empty;
	logic                         push;
	logic                         pop;
	logic [cotq_pkg::PTR_W-1:0]   tail_nx;
	logic [cotq_pkg::PTR_W-1:0]   head_nx;

	always_comb begin
		if (sample_q < empty_limit_q) cls = cotq_pkg::CLS_EMPTY;
		else if (sample_q < small_limit_q) cls = cotq_pkg::CLS_SMALL;
		else if (sample_q < medium_limit_q) cls = cotq_pkg::CLS_MEDIUM;
		else cls = cotq_pkg::CLS_LARGE;
	end

	assign is_sample = (action_q == cotq_pkg::ACT_SAMPLE);
	assign rise      = (last_class_q == cotq_pkg::CLS_EMPTY) & (cls != cotq_pkg::CLS_EMPTY);
	assign full      = (count_q == cotq_pkg::CNT_W'(cotq_pkg::QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign push      = cmd.exec & is_sample & rise & ~full;
	assign pop       = cmd.exec & ~is_sample & ~empty;

	assign tail_nx = (tail_q == cotq_pkg::PTR_W'(cotq_pkg::QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign head_nx = (head_q == cotq_pkg::PTR_W'(cotq_pkg::QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_limit_q  <= cotq_pkg::EMPTY_LIMIT_RST;
			small_limit_q  <= cotq_pkg::SMALL_LIMIT_RST;
			medium_limit_q <= cotq_pkg::MEDIUM_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				cotq_pkg::REG_EMPTY_LIMIT:  empty_limit_q  <= cfg_data;
				cotq_pkg::REG_SMALL_LIMIT:  small_limit_q  <= cfg_data;
				cotq_pkg::REG_MEDIUM_LIMIT: medium_limit_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_class_q <= cotq_pkg::CLS_EMPTY;
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			total_q      <= '0;
		end else if (cmd.exec) begin
			if (is_sample) last_class_q <= cls;
			if (push) begin
				tail_q  <= tail_nx;
				count_q <= count_q + 1'b1;
				total_q <= total_q + 1'b1;
			end
			if (pop) begin
				head_q  <= head_nx;
				count_q <= count_q - 1'b1;
			end
		end
	end

	// type store: one write port (tail), one registered read port (head)
	always_ff @(posedge clk) begin
		if (push) mem_q[tail_q] <= cls;
		if (cmd.exec) rd_q <= mem_q[head_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= action;
			sample_q <= sample_value;
		end
		if (cmd.exec) begin
			res_cls_q   <= is_sample ? cls : cotq_pkg::CLS_EMPTY;
			res_new_q   <= is_sample & rise & ~full;
			res_drop_q  <= is_sample & rise & full;
			res_empty_q <= ~is_sample & empty;
			res_pop_q   <= ~is_sample & ~empty;
		end
		if (cmd.load) begin
			class_now       <= res_cls_q;
			new_object      <= res_new_q;
			object_number   <= total_q;
			overflow_drop   <= res_drop_q;
			dequeued_type   <= res_pop_q ? rd_q : cotq_pkg::CLS_EMPTY;
			queue_was_empty <= res_empty_q;
		end
	end

endmodule

>>> tb/cotq_scoreboard.sv
// ----------------------------------------------------------------------------
// cotq_scoreboard
// Watches the input, result and register channels of the conveyor object
// type queue. It tracks the limits and the type ring of its own, works out the
// result word of every accepted input word, and checks each accepted result
// word field by field against the oldest one still owed.
// ----------------------------------------------------------------------------
module cotq_scoreboard (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic                           action,
	input  logic [cotq_pkg::LIMIT_W-1:0]   sample_value,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [cotq_pkg::CLASS_W-1:0]   class_now,
	input  logic                           new_object,
	input  logic [cotq_pkg::TOTAL_W-1:0]   object_number,
	input  logic                           overflow_drop,
	input  logic [cotq_pkg::CLASS_W-1:0]   dequeued_type,
	input  logic                           queue_was_empty,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [cotq_pkg::INDEX_W-1:0]   cfg_index,
	input  logic [cotq_pkg::LIMIT_W-1:0]   cfg_data,
	output int unsigned                    owed,
	output int unsigned                    fails
);

	typedef struct packed {
		logic [cotq_pkg::CLASS_W-1:0] cls;
		logic                         fresh;
		logic [cotq_pkg::TOTAL_W-1:0] total;
		logic                         drop;
		logic [cotq_pkg::CLASS_W-1:0] dtype;
		logic                         was_empty;
	} tally_t;

	logic [cotq_pkg::LIMIT_W-1:0] lim_empty, lim_small, lim_medium;
	logic [cotq_pkg::CLASS_W-1:0] prev_cls;
	logic [cotq_pkg::CLASS_W-1:0] ring [cotq_pkg::QUEUE_DEPTH];
	logic [cotq_pkg::PTR_W-1:0]   head, tail;
	logic [cotq_pkg::CNT_W-1:0]   held;
	logic [cotq_pkg::TOTAL_W-1:0] obj_total;
	tally_t                       owed_words [$];
	tally_t                       want;

	function automatic logic [cotq_pkg::CLASS_W-1:0] sort_sample(
		logic [cotq_pkg::LIMIT_W-1:0] val);
		if (val < lim_empty)
			return cotq_pkg::CLS_EMPTY;
		if (val < lim_small)
			return cotq_pkg::CLS_SMALL;
		if (val < lim_medium)
			return cotq_pkg::CLS_MEDIUM;
		return cotq_pkg::CLS_LARGE;
	endfunction

	function automatic logic [cotq_pkg::PTR_W-1:0] bump(logic [cotq_pkg::PTR_W-1:0] idx);
		return (idx == cotq_pkg::PTR_W'(cotq_pkg::QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
	endfunction

	// next result word; updates the ring and counters
	function automatic tally_t run_item(logic act, logic [cotq_pkg::LIMIT_W-1:0] val);
		tally_t                       t;
		logic [cotq_pkg::CLASS_W-1:0] c;
		t = '0;
		if (act == cotq_pkg::ACT_SAMPLE) begin
			c = sort_sample(val);
			t.cls = c;
			if (prev_cls == cotq_pkg::CLS_EMPTY && c != cotq_pkg::CLS_EMPTY) begin
				if (held < cotq_pkg::CNT_W'(cotq_pkg::QUEUE_DEPTH)) begin
					ring[tail] = c;
					tail       = bump(tail);
					held       = held + 1'b1;
					obj_total  = obj_total + 1'b1;
					t.fresh    = 1'b1;
				end else begin
					t.drop = 1'b1;
				end
			end
			prev_cls = c;
		end else if (held == '0) begin
			t.was_empty = 1'b1;
		end else begin
			t.dtype = ring[head];
			head    = bump(head);
			held    = held - 1'b1;
		end
		t.total = obj_total;
		return t;
	endfunction

	task automatic check_field(string label, int unsigned exp_val, int unsigned got_val);
		if (exp_val != got_val) begin
			fails++;
			$error("%s expected %0d actual %0d", label, exp_val, got_val);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_empty  = cotq_pkg::EMPTY_LIMIT_RST;
			lim_small  = cotq_pkg::SMALL_LIMIT_RST;
			lim_medium = cotq_pkg::MEDIUM_LIMIT_RST;
			prev_cls   = cotq_pkg::CLS_EMPTY;
			head       = '0;
			tail       = '0;
			held       = '0;
			obj_total  = '0;
			owed_words.delete();
			owed       = 0;
			fails      = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					cotq_pkg::REG_EMPTY_LIMIT:  lim_empty  = cfg_data;
					cotq_pkg::REG_SMALL_LIMIT:  lim_small  = cfg_data;
					cotq_pkg::REG_MEDIUM_LIMIT: lim_medium = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				owed_words.push_back(run_item(action, sample_value));
			if (out_valid && !out_stall) begin
				if (owed_words.size() == 0) begin
					fails++;
					$error("result word with none expected");
				end else begin
					want = owed_words.pop_front();
					check_field("class_now", 32'(want.cls), 32'(class_now));
					check_field("new_object", 32'(want.fresh), 32'(new_object));
					check_field("object_number", 32'(want.total), 32'(object_number));
					check_field("overflow_drop", 32'(want.drop), 32'(overflow_drop));
					check_field("dequeued_type", 32'(want.dtype), 32'(dequeued_type));
					check_field("queue_was_empty", 32'(want.was_empty),
						32'(queue_was_empty));
				end
			end
			owed = owed_words.size();
		end
	end

endmodule

>>> tb/conveyor_object_type_queue_tb.sv
// ----------------------------------------------------------------------------
// conveyor_object_type_queue_tb
// Drives sample and dequeue words into the conveyor object type queue under
// several limit settings (defaults, ordered, unordered, all zero, all ones),
// with random idling on both channels. Checking is done by cotq_scoreboard;
// this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module conveyor_object_type_queue_tb;

	localparam logic [cotq_pkg::INDEX_W-1:0] REG_SPARE = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 200_000;
	localparam int unsigned SEG_WORDS   = 120;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	logic                         action;
	logic [cotq_pkg::LIMIT_W-1:0] sample_value;
	logic                         out_valid;
	logic                         out_stall;
	logic [cotq_pkg::CLASS_W-1:0] class_now;
	logic                         new_object;
	logic [cotq_pkg::TOTAL_W-1:0] object_number;
	logic                         overflow_drop;
	logic [cotq_pkg::CLASS_W-1:0] dequeued_type;
	logic                         queue_was_empty;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [cotq_pkg::INDEX_W-1:0] cfg_index;
	logic [cotq_pkg::LIMIT_W-1:0] cfg_data;

	int unsigned                  owed;
	int unsigned                  fails;
	int unsigned                  cycles = 0;
	int unsigned                  send_idle_pct;
	int unsigned                  stall_pct;
	int unsigned                  dq_pct;
	logic [cotq_pkg::LIMIT_W-1:0] lim_e, lim_s, lim_m;

	always #6 clk = ~clk;

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	conveyor_object_type_queue u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (action),
		.sample_value    (sample_value),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.class_now       (class_now),
		.new_object      (new_object),
		.object_number   (object_number),
		.overflow_drop   (overflow_drop),
		.dequeued_type   (dequeued_type),
		.queue_was_empty (queue_was_empty),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	cotq_scoreboard u_scoreboard (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (action),
		.sample_value    (sample_value),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.class_now       (class_now),
		.new_object      (new_object),
		.object_number   (object_number),
		.overflow_drop   (overflow_drop),
		.dequeued_type   (dequeued_type),
		.queue_was_empty (queue_was_empty),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.owed            (owed),
		.fails           (fails)
	);

	task automatic offer_word(logic act, int unsigned val);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		action       <= act;
		sample_value <= cotq_pkg::LIMIT_W'(val);
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_owed_clear();
		@(negedge clk);
		in_valid <= 1'b0;
		while (owed != 0)
			@(negedge clk);
	endtask

	task automatic write_limit(logic [cotq_pkg::INDEX_W-1:0] idx, int unsigned val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= cotq_pkg::LIMIT_W'(val);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			cotq_pkg::REG_EMPTY_LIMIT:  lim_e = cotq_pkg::LIMIT_W'(val);
			cotq_pkg::REG_SMALL_LIMIT:  lim_s = cotq_pkg::LIMIT_W'(val);
			cotq_pkg::REG_MEDIUM_LIMIT: lim_m = cotq_pkg::LIMIT_W'(val);
			default: ;
		endcase
	endtask

	task automatic set_limits(int unsigned e, int unsigned s, int unsigned m);
		wait_owed_clear();
		write_limit(cotq_pkg::REG_EMPTY_LIMIT, e);
		write_limit(cotq_pkg::REG_SMALL_LIMIT, s);
		write_limit(cotq_pkg::REG_MEDIUM_LIMIT, m);
	endtask

	task automatic pick_ordered_limits();
		lim_e = cotq_pkg::LIMIT_W'($urandom_range(500, 1));
		lim_s = cotq_pkg::LIMIT_W'($urandom_range(800, 32'(lim_e)));
		lim_m = cotq_pkg::LIMIT_W'($urandom_range(1023, 32'(lim_s)));
	endtask

	// values near the limits, biased to an object or to no object
	function automatic int unsigned pick_sample(bit obj);
		int unsigned e, s, m;
		e = 32'(lim_e);
		s = (lim_s > lim_e) ? 32'(lim_s) : 32'(lim_e);
		m = (lim_m > lim_e) ? 32'(lim_m) : 32'(lim_e);
		if (obj) begin
			case ($urandom_range(5))
				0: return e;
				1: return s;
				2: return m;
				3: return 1023;
				4: return (s > e) ? s - 1 : e;
				default: return $urandom_range(1023, e);
			endcase
		end
		if (e == 0)
			return $urandom_range(1023);
		case ($urandom_range(2))
			0: return 0;
			1: return e - 1;
			default: return $urandom_range(e - 1, 0);
		endcase
	endfunction

	task automatic random_segment(int unsigned count);
		int unsigned done;
		int unsigned r;
		int unsigned v;
		done = 0;
		while (done < count) begin
			r = $urandom_range(99);
			if (r < dq_pct) begin
				offer_word(cotq_pkg::ACT_DEQUEUE, $urandom_range(1023));
				done++;
			end else if (r < dq_pct + 60) begin
				repeat ($urandom_range(3, 1)) begin
					offer_word(cotq_pkg::ACT_SAMPLE, pick_sample(1'b0));
					done++;
				end
				v = pick_sample(1'b1);
				repeat ($urandom_range(3, 1)) begin
					offer_word(cotq_pkg::ACT_SAMPLE, v);
					done++;
				end
			end else if (r < 98) begin
				offer_word(cotq_pkg::ACT_SAMPLE, $urandom_range(1023));
				done++;
			end else begin
				wait_owed_clear();
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		action        = cotq_pkg::ACT_SAMPLE;
		sample_value  = '0;
		out_stall     = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = cotq_pkg::REG_EMPTY_LIMIT;
		cfg_data      = '0;
		lim_e         = cotq_pkg::EMPTY_LIMIT_RST;
		lim_s         = cotq_pkg::SMALL_LIMIT_RST;
		lim_m         = cotq_pkg::MEDIUM_LIMIT_RST;
		send_idle_pct = 13;
		stall_pct     = 66;
		dq_pct        = 10;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// spare index must leave the defaults alone
		write_limit(REG_SPARE, 1023);

		offer_word(cotq_pkg::ACT_DEQUEUE, 0);
		offer_word(cotq_pkg::ACT_SAMPLE, 0);
		offer_word(cotq_pkg::ACT_SAMPLE, 1023);
		offer_word(cotq_pkg::ACT_SAMPLE, 63);
		offer_word(cotq_pkg::ACT_SAMPLE, 64);
		offer_word(cotq_pkg::ACT_SAMPLE, 127);
		offer_word(cotq_pkg::ACT_SAMPLE, 128);
		offer_word(cotq_pkg::ACT_SAMPLE, 212);
		offer_word(cotq_pkg::ACT_SAMPLE, 213);
		offer_word(cotq_pkg::ACT_SAMPLE, 0);
		offer_word(cotq_pkg::ACT_SAMPLE, 200);
		offer_word(cotq_pkg::ACT_DEQUEUE, 1023);
		offer_word(cotq_pkg::ACT_SAMPLE, 63);
		offer_word(cotq_pkg::ACT_DEQUEUE, 0);
		offer_word(cotq_pkg::ACT_SAMPLE, 130);
		offer_word(cotq_pkg::ACT_DEQUEUE, 0);
		offer_word(cotq_pkg::ACT_DEQUEUE, 0);
		offer_word(cotq_pkg::ACT_DEQUEUE, 0);
		offer_word(cotq_pkg::ACT_SAMPLE, 1023);

		pick_ordered_limits();
		set_limits(32'(lim_e), 32'(lim_s), 32'(lim_m));
		dq_pct = 10;
		random_segment(SEG_WORDS);

		set_limits(1023, 1023, 1023);
		dq_pct = 30;
		random_segment(SEG_WORDS);

		wait_owed_clear();
		send_idle_pct = 66;
		stall_pct     = 13;
		set_limits($urandom_range(1023), $urandom_range(1023), $urandom_range(1023));
		dq_pct = 10;
		random_segment(SEG_WORDS);

		set_limits(0, 0, 0);
		dq_pct = 30;
		random_segment(SEG_WORDS);

		wait_owed_clear();
		send_idle_pct = 0;
		stall_pct     = 0;
		pick_ordered_limits();
		set_limits(32'(lim_e), 32'(lim_s), 32'(lim_m));
		dq_pct = 5;
		random_segment(SEG_WORDS);

		set_limits(32'(cotq_pkg::EMPTY_LIMIT_RST), 32'(cotq_pkg::SMALL_LIMIT_RST),
			32'(cotq_pkg::MEDIUM_LIMIT_RST));
		dq_pct = 30;
		random_segment(SEG_WORDS);

		wait_owed_clear();
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
